// ----- sv/rvn_pkg.sv -----
// shared types and constants for the rms vector normalizer
`timescale 1ns / 1ps
package rvn_pkg;

  localparam int unsigned MaxLengthDefault = 256;

  typedef struct packed {
    logic               command;
    logic signed [15:0] element_value;
    logic signed [15:0] gain_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normalized_value;
    logic [7:0]         element_index;
    logic               last_flag;
    logic               error_flag;
  } out_item_t;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEmit = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_MEAN,
    ST_SET_M,
    ST_RECIP_INIT,
    ST_DIV_RECIP,
    ST_SQRT,
    ST_SET_SCALE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_EMIT_OUT,
    ST_ERR_OUT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic do_load;
    logic div_mean_init;
    logic set_m;
    logic recip_init;
    logic sqrt_init;
    logic step_div;
    logic step_sqrt;
    logic set_scale;
    logic mem_rd;
    logic mul1;
    logic mul2;
    logic emit_out;
    logic err_out;
  } dp_cmd_t;

  typedef struct packed {
    logic load_full;
    logic emit_bad;
    logic scale_ready;
    logic iter_last;
    logic m_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- sv/rvn_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module rvn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rvn_ctrl.sv -----
// sequencing state machine for load, scale computation and emit
`timescale 1ns / 1ps
module rvn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_stall,
  input  rvn_pkg::dp_stat_t stat,
  output rvn_pkg::dp_cmd_t  cmd
);

  rvn_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rvn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      rvn_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          if (in_cmd == rvn_pkg::CmdLoad) begin
            state_nxt = stat.load_full ? rvn_pkg::ST_ERR_OUT : rvn_pkg::ST_LOAD;
          end else if (stat.emit_bad) begin
            state_nxt = rvn_pkg::ST_ERR_OUT;
          end else if (stat.scale_ready) begin
            state_nxt = rvn_pkg::ST_READ;
          end else begin
            cmd.div_mean_init = 1'b1;
            state_nxt = rvn_pkg::ST_DIV_MEAN;
          end
        end
      end
      rvn_pkg::ST_LOAD: begin
        cmd.do_load = 1'b1;
        state_nxt = rvn_pkg::ST_IDLE;
      end
      rvn_pkg::ST_DIV_MEAN: begin
        cmd.step_div = 1'b1;
        if (stat.iter_last) state_nxt = rvn_pkg::ST_SET_M;
      end
      rvn_pkg::ST_SET_M: begin
        cmd.set_m = 1'b1;
        state_nxt = rvn_pkg::ST_RECIP_INIT;
      end
      rvn_pkg::ST_RECIP_INIT: begin
        if (stat.m_zero) begin
          cmd.set_scale = 1'b1;
          state_nxt = rvn_pkg::ST_READ;
        end else begin
          cmd.recip_init = 1'b1;
          state_nxt = rvn_pkg::ST_DIV_RECIP;
        end
      end
      rvn_pkg::ST_DIV_RECIP: begin
        cmd.step_div = 1'b1;
        if (stat.iter_last) begin
          state_nxt = rvn_pkg::ST_SQRT;
        end
      end
      rvn_pkg::ST_SQRT: begin
        cmd.step_sqrt = 1'b1;
        if (stat.iter_last) state_nxt = rvn_pkg::ST_SET_SCALE;
      end
      rvn_pkg::ST_SET_SCALE: begin
        cmd.set_scale = 1'b1;
        state_nxt = rvn_pkg::ST_READ;
      end
      rvn_pkg::ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt = rvn_pkg::ST_MUL1;
      end
      rvn_pkg::ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = rvn_pkg::ST_MUL2;
      end
      rvn_pkg::ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = rvn_pkg::ST_EMIT_OUT;
      end
      rvn_pkg::ST_EMIT_OUT: begin
        if (stat.out_free) begin
          cmd.emit_out = 1'b1;
          state_nxt = rvn_pkg::ST_IDLE;
        end
      end
      rvn_pkg::ST_ERR_OUT: begin
        if (stat.out_free) begin
          cmd.err_out = 1'b1;
          state_nxt = rvn_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rvn_pkg::ST_IDLE;
    endcase
    // the last divide step hands straight over to the root
    if (state_r == rvn_pkg::ST_DIV_RECIP && stat.iter_last) cmd.sqrt_init = 1'b1;
  end

endmodule

// ----- sv/rvn_dp.sv -----
// vector state, shared divide / root unit, multiply and rounding datapath
`timescale 1ns / 1ps
module rvn_dp #(
  parameter int unsigned MAX_LENGTH = rvn_pkg::MaxLengthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rvn_pkg::in_item_t in_data,
  input  logic [15:0]       epsilon,
  input  rvn_pkg::dp_cmd_t  cmd,
  output rvn_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_stall,
  output rvn_pkg::out_item_t out_data
);

  localparam int unsigned CW  = $clog2(MAX_LENGTH + 1);
  localparam int unsigned AW  = $clog2(MAX_LENGTH);
  localparam int unsigned SW  = 30 + CW;
  localparam int unsigned DVW = (SW > 52) ? SW : 52;
  localparam int unsigned ICW = $clog2(DVW);

  rvn_pkg::in_item_t  item_r;
  logic [SW-1:0]      sum_r;
  logic [CW-1:0]      count_r, pos_r;
  logic [31:0]        scale_r;
  logic               ready_r, m_zero_r;
  logic [DVW-1:0]     dq_r;
  logic [30:0]        rem_r, dvs_r;
  logic [25:0]        root_r;
  logic [ICW-1:0]     iter_r;
  logic [48:0]        p1_r;
  logic [62:0]        p2_r;
  logic               neg_r;
  logic               out_valid_r;
  rvn_pkg::out_item_t out_r;

  logic               restart;
  logic [CW-1:0]      base_count;
  logic [31:0]        sq;
  logic [15:0]        rd_data;
  logic [31:0]        rem_sh, sq_rs, sq_trial;
  logic               div_ge, sq_ge;
  logic [31:0]        m_val, scale_rnd;
  logic [16:0]        ev17, ae, gv17, ag;
  logic [64:0]        p2_full;
  logic signed [63:0] v_s, t_s;
  logic signed [35:0] r_s;
  logic signed [15:0] sat;

  assign restart    = (pos_r != '0);
  assign base_count = restart ? '0 : count_r;
  assign sq         = 32'($signed(item_r.element_value) * $signed(item_r.element_value));

  rvn_ram #(.WIDTH(16), .DEPTH(MAX_LENGTH)) u_store (
    .clk   (clk),
    .we    (cmd.do_load),
    .waddr (base_count[AW-1:0]),
    .wdata (item_r.element_value),
    .raddr (pos_r[AW-1:0]),
    .rdata (rd_data)
  );

  // restoring divide, one quotient bit per step
  assign rem_sh = {rem_r, dq_r[DVW-1]};
  assign div_ge = rem_sh >= {1'b0, dvs_r};
  // digit-by-digit square root, two radicand bits per step
  assign sq_rs    = {rem_r[29:0], dq_r[51:50]};
  assign sq_trial = {4'b0, root_r, 2'b01};
  assign sq_ge    = sq_rs >= sq_trial;

  assign m_val     = 32'(dq_r) + {16'b0, epsilon};
  assign scale_rnd = {6'b0, root_r} + 32'd1;

  assign ev17 = {rd_data[15], rd_data};
  assign ae   = rd_data[15] ? 17'(-ev17) : ev17;
  assign gv17 = {item_r.gain_value[15], item_r.gain_value};
  assign ag   = item_r.gain_value[15] ? 17'(-gv17) : gv17;
  assign p2_full = {16'b0, p1_r} * {48'b0, ag};

  // round half up at bit 27, then saturate to q8.8
  assign v_s = neg_r ? -$signed({1'b0, p2_r}) : $signed({1'b0, p2_r});
  assign t_s = v_s + 64'sd134217728;
  assign r_s = 36'(t_s >>> 28);
  always_comb begin
    if (r_s > 36'sd32767) sat = 16'sh7fff;
    else if (r_s < -36'sd32768) sat = -16'sh8000;
    else sat = r_s[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.do_load) begin
        sum_r   <= (restart ? '0 : sum_r) + SW'(sq);
        count_r <= base_count + 1'b1;
        pos_r   <= '0;
        ready_r <= 1'b0;
      end
      if (cmd.set_scale) ready_r <= 1'b1;
      if (cmd.emit_out) pos_r <= pos_r + 1'b1;
      if (cmd.emit_out || cmd.err_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) item_r <= in_data;
    if (cmd.div_mean_init) begin
      dq_r   <= DVW'(sum_r);
      rem_r  <= '0;
      dvs_r  <= 31'(count_r);
      iter_r <= ICW'(DVW - 1);
    end else if (cmd.recip_init) begin
      dq_r   <= DVW'(52'h4_0000_0000_0000);
      rem_r  <= '0;
      iter_r <= ICW'(DVW - 1);
    end else if (cmd.sqrt_init) begin
      dq_r   <= {dq_r[DVW-2:0], div_ge};
      rem_r  <= '0;
      root_r <= '0;
      iter_r <= ICW'(25);
    end else if (cmd.step_div) begin
      dq_r   <= {dq_r[DVW-2:0], div_ge};
      rem_r  <= div_ge ? 31'(rem_sh - {1'b0, dvs_r}) : rem_sh[30:0];
      iter_r <= iter_r - 1'b1;
    end else if (cmd.step_sqrt) begin
      dq_r   <= {dq_r[DVW-3:0], 2'b00};
      rem_r  <= sq_ge ? 31'(sq_rs - sq_trial) : sq_rs[30:0];
      root_r <= {root_r[24:0], sq_ge};
      iter_r <= iter_r - 1'b1;
    end
    if (cmd.set_m) begin
      dvs_r    <= m_val[30:0];
      m_zero_r <= (m_val == '0);
    end
    if (cmd.set_scale) scale_r <= m_zero_r ? 32'hffff_ffff : {1'b0, scale_rnd[31:1]};
    if (cmd.mul1) begin
      p1_r  <= {32'b0, ae} * {17'b0, scale_r};
      neg_r <= rd_data[15] ^ item_r.gain_value[15];
    end
    if (cmd.mul2) p2_r <= p2_full[62:0];
    if (cmd.emit_out) begin
      out_r.normalized_value <= sat;
      out_r.element_index    <= 8'(pos_r);
      out_r.last_flag        <= (pos_r + 1'b1 == count_r);
      out_r.error_flag       <= 1'b0;
    end else if (cmd.err_out) begin
      out_r <= '{normalized_value: '0, element_index: '0, last_flag: 1'b0, error_flag: 1'b1};
    end
  end

  assign stat.load_full   = !restart && (count_r == CW'(MAX_LENGTH));
  assign stat.emit_bad    = (count_r == '0) || (pos_r >= count_r);
  assign stat.scale_ready = ready_r;
  assign stat.iter_last   = (iter_r == '0);
  assign stat.m_zero      = m_zero_r;
  assign stat.out_free    = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LENGTH)) else $error("element count above capacity");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= count_r) else $error("emit position past element count");
  a_scale_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_r) |-> pos_r == '0) else $error("scale set after emission began");
`endif

endmodule

// ----- sv/rms_vector_normalizer_core.sv -----
// top level of the rms vector normalizer
`timescale 1ns / 1ps
// RMS normalization of one vector of signed q8.8 elements (up to MAX_LENGTH).
// A load beat stores one element. The first emit beat of a vector
// runs the mean divide, reciprocal divide and square root on one shared
// iterative unit (reciprocal and root are skipped when mean plus epsilon
// is zero); every emit then passes through the element memory read and two
// multiplies. Errors (emit with nothing left, load when full) return one
// beat with error_flag set. epsilon sits at byte address 0.
module rms_vector_normalizer_core #(
  parameter int unsigned MAX_LENGTH = rvn_pkg::MaxLengthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rvn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rvn_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  rvn_pkg::dp_cmd_t  cmd;
  rvn_pkg::dp_stat_t stat;
  logic [15:0]       epsilon_r;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'b0, epsilon_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epsilon_r <= 16'd1;
    end else if (psel && penable && pwrite && pready) begin
      epsilon_r <= pwdata[15:0];
    end
  end

  rvn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.command),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rvn_dp #(.MAX_LENGTH(MAX_LENGTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .epsilon   (epsilon_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
